### hdl/psra_pkg.sv
package psra_pkg;

    // Ring geometry and sample precision
    localparam int RING_DEPTH  = 50;
    localparam int SAMPLE_BITS = 16;

    // Derived widths
    localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(RING_DEPTH) + 1;
    localparam int DIVC_W = $clog2(SUM_W + 1);

    // Fixed port widths
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TIME_W     = 32;
    localparam int STEPS_W    = 16;
    localparam int VAL_W      = 16;
    localparam int OP_W       = 2;
    localparam int EV_W       = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 16'd100;
    localparam logic [CFG_W-1:0] REPORT_INTERVAL_RST = 16'd500;
    localparam logic [CFG_W-1:0] STEP_DELAY_RST      = 16'd20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY      = 2'd2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

    // Event codes
    localparam logic [EV_W-1:0] EV_STEP     = 3'd0;
    localparam logic [EV_W-1:0] EV_REPORT   = 3'd1;
    localparam logic [EV_W-1:0] EV_ACCEPTED = 3'd2;
    localparam logic [EV_W-1:0] EV_BUSY     = 3'd3;
    localparam logic [EV_W-1:0] EV_INVALID  = 3'd4;
    localparam logic [EV_W-1:0] EV_STOPPED  = 3'd5;

    // One result transaction
    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic               step_pulse;
        logic               step_reverse;
        logic               release_motor;
        logic [STEPS_W-1:0] steps_left;
        logic [VAL_W-1:0]   instant_value;
        logic [VAL_W-1:0]   mean_value;
    } res_t;

endpackage

### hdl/paced_stepper_with_rolling_average_core.sv
// Commands and steps register their result in the output register, or in the
// holding slot while the output is stalled. A report sums the ring with
// filled_count memory reads (one memory read per cycle), divides the SUM_W-bit
// magnitude (23 here) bit-serially and ends in a finish state. Throughput: one
// transaction per cycle; a report in progress or a waiting result stalls the input.
// Reset (async, active low) clears control state and loads the intervals
// 100/500/20; ring contents are not cleared, only filled entries are read.
module paced_stepper_with_rolling_average_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [psra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psra_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [psra_pkg::OP_W-1:0]           operation,
    input  logic [psra_pkg::TIME_W-1:0]         now_ms,
    input  logic signed [psra_pkg::VAL_W-1:0]   accel_sample,
    input  logic [psra_pkg::STEPS_W-1:0]        move_steps,
    input  logic                                move_backward,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [psra_pkg::EV_W-1:0]           event_res,
    output logic                                step_pulse,
    output logic                                step_reverse,
    output logic                                release_motor,
    output logic [psra_pkg::STEPS_W-1:0]        steps_left,
    output logic signed [psra_pkg::VAL_W-1:0]   instant_value,
    output logic signed [psra_pkg::VAL_W-1:0]   mean_value
);
    import psra_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Configuration registers
    logic [CFG_W-1:0] sample_interval_reg;
    logic [CFG_W-1:0] report_interval_reg;
    logic [CFG_W-1:0] step_delay_reg;

    // Control state
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [TIME_W-1:0]  last_sample_reg, last_sample_next;
    logic [TIME_W-1:0]  last_report_reg, last_report_next;
    logic [TIME_W-1:0]  last_step_reg, last_step_next;
    logic [STEPS_W-1:0] pending_reg, pending_next;
    logic               backward_reg, backward_next;

    // Report datapath
    logic [CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [SUM_W-1:0]        num_reg, num_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic [DIVC_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [VAL_W-1:0]        inst_reg, inst_next;

    // Ring memory
    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   ring_we;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;

    // Output register plus one holding slot
    res_t out_reg, hold_reg;
    logic out_vld_reg, hold_vld_reg;
    res_t new_res;
    logic new_vld;
    logic out_free;

    // Helpers
    logic                          in_acc;
    logic signed [SAMPLE_BITS-1:0] sample_s;
    logic signed [VAL_W-1:0]       sample_out;
    logic [TIME_W-1:0]             step_age, sample_age, report_age;
    logic [CNT_W:0]                trial, trial_diff;
    logic                          qbit;
    logic signed [SUM_W-1:0]       mean_s;
    logic signed [47:0]            mean_wide;

    assign in_stall = (state_reg != ST_IDLE) || hold_vld_reg;
    assign in_acc   = in_valid && !in_stall;

    assign sample_s   = SAMPLE_BITS'(accel_sample);
    assign sample_out = VAL_W'(sample_s);

    // Wrapping time differences
    assign step_age   = now_ms - last_step_reg;
    assign sample_age = now_ms - last_sample_reg;
    assign report_age = now_ms - last_report_reg;

    // Restoring division step on the magnitude
    assign trial      = {rem_reg, num_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, filled_reg};
    assign qbit       = (trial >= {1'b0, filled_reg});
    assign mean_s     = neg_reg ? -$signed(num_reg) : $signed(num_reg);
    assign mean_wide  = 48'(mean_s);

    assign rd_addr = rd_cnt_reg[IDX_W-1:0];

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        filled_next      = filled_reg;
        last_sample_next = last_sample_reg;
        last_report_next = last_report_reg;
        last_step_next   = last_step_reg;
        pending_next     = pending_reg;
        backward_next    = backward_reg;
        rd_cnt_next      = rd_cnt_reg;
        rd_vld_next      = rd_vld_reg;
        acc_next         = acc_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        neg_next         = neg_reg;
        div_cnt_next     = div_cnt_reg;
        inst_next        = inst_reg;
        ring_we          = 1'b0;
        rd_en            = 1'b0;
        new_vld          = 1'b0;
        new_res          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (operation)
                        OP_START:
                        begin
                            new_vld            = 1'b1;
                            new_res.steps_left = pending_reg;
                            if (move_steps == '0)
                            begin
                                new_res.event_res = EV_INVALID;
                            end
                            else if (pending_reg != '0)
                            begin
                                new_res.event_res = EV_BUSY;
                            end
                            else
                            begin
                                backward_next      = move_backward;
                                pending_next       = move_steps;
                                last_step_next     = now_ms;
                                new_res.event_res  = EV_ACCEPTED;
                                new_res.steps_left = move_steps;
                            end
                        end
                        OP_STOP:
                        begin
                            pending_next          = '0;
                            new_vld               = 1'b1;
                            new_res.event_res     = EV_STOPPED;
                            new_res.release_motor = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            slot_next        = '0;
                            filled_next      = '0;
                            last_sample_next = now_ms;
                            last_report_next = now_ms;
                            pending_next     = '0;
                        end
                        OP_TICK:
                        begin
                            if (pending_reg != '0)
                            begin
                                // move in progress: pace the steps
                                if (step_age >= TIME_W'(step_delay_reg))
                                begin
                                    last_step_next        = now_ms;
                                    pending_next          = pending_reg - 1'b1;
                                    new_vld               = 1'b1;
                                    new_res.event_res     = EV_STEP;
                                    new_res.step_pulse    = 1'b1;
                                    new_res.step_reverse  = backward_reg;
                                    new_res.release_motor = (pending_reg == STEPS_W'(1));
                                    new_res.steps_left    = pending_reg - 1'b1;
                                    new_res.instant_value = sample_out;
                                end
                            end
                            else if (sample_age >= TIME_W'(sample_interval_reg))
                            begin
                                // idle: store the sample
                                last_sample_next = now_ms;
                                ring_we          = 1'b1;
                                slot_next        = (slot_reg == IDX_W'(RING_DEPTH - 1))
                                                   ? '0 : slot_reg + 1'b1;
                                if (filled_reg < CNT_W'(RING_DEPTH))
                                begin
                                    filled_next = filled_reg + 1'b1;
                                end
                                if (report_age >= TIME_W'(report_interval_reg))
                                begin
                                    last_report_next = now_ms;
                                    inst_next        = sample_out;
                                    acc_next         = '0;
                                    rd_cnt_next      = '0;
                                    rd_vld_next      = 1'b0;
                                    state_next       = ST_SUM;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                // one read issued, one sample accumulated per cycle
                rd_vld_next = 1'b0;
                if (rd_cnt_reg < filled_reg)
                begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    acc_next = acc_reg + SUM_W'($signed(rd_data_reg));
                end
                else if (rd_cnt_reg == filled_reg)
                begin
                    neg_next     = acc_reg[SUM_W-1];
                    num_next     = acc_reg[SUM_W-1] ? 
                                   SUM_W'(-acc_reg) : SUM_W'(acc_reg);
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = qbit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
                num_next     = {num_reg[SUM_W-2:0], qbit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIVC_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                new_vld               = 1'b1;
                new_res.event_res     = EV_REPORT;
                new_res.instant_value = inst_reg;
                new_res.mean_value    = mean_wide[VAL_W-1:0];
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot_reg] <= sample_s;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= SAMPLE_INTERVAL_RST;
            report_interval_reg <= REPORT_INTERVAL_RST;
            step_delay_reg      <= STEP_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                REG_REPORT_INTERVAL: report_interval_reg <= cfg_data;
                REG_STEP_DELAY:      step_delay_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            slot_reg        <= '0;
            filled_reg      <= '0;
            last_sample_reg <= '0;
            last_report_reg <= '0;
            last_step_reg   <= '0;
            pending_reg     <= '0;
            backward_reg    <= 1'b0;
            rd_cnt_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            filled_reg      <= filled_next;
            last_sample_reg <= last_sample_next;
            last_report_reg <= last_report_next;
            last_step_reg   <= last_step_next;
            pending_reg     <= pending_next;
            backward_reg    <= backward_next;
            rd_cnt_reg      <= rd_cnt_next;
            rd_vld_reg      <= rd_vld_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

    // Arithmetic payload
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        inst_reg <= inst_next;
    end

    // Output register with a holding slot behind it
    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (hold_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                hold_vld_reg <= new_vld;
            end
            else
            begin
                out_vld_reg <= new_vld;
            end
        end
        else if (new_vld)
        begin
            hold_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (hold_vld_reg)
            begin
                out_reg  <= hold_reg;
                hold_reg <= new_res;
            end
            else
            begin
                out_reg <= new_res;
            end
        end
        else if (new_vld)
        begin
            hold_reg <= new_res;
        end
    end

    // Output ports
    assign out_valid     = out_vld_reg;
    assign event_res     = out_reg.event_res;
    assign step_pulse    = out_reg.step_pulse;
    assign step_reverse  = out_reg.step_reverse;
    assign release_motor = out_reg.release_motor;
    assign steps_left    = out_reg.steps_left;
    assign instant_value = out_reg.instant_value;
    assign mean_value    = out_reg.mean_value;

endmodule

### test/tb_paced_stepper_with_rolling_average_core.sv
module tb_paced_stepper_with_rolling_average_core;
    timeunit 1ns;
    timeprecision 1ps;

    import psra_pkg::*;

    // Index 3 has no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int  DRAIN_CYCLES = 100;
    localparam int  ACTIVE_PCT   = 22;
    localparam bit  BY_MODEL     = 1'b0;
    localparam bit  TYPED        = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TIME_W-1:0]  now;
        logic [VAL_W-1:0]   sample;
        logic [STEPS_W-1:0] steps;
        logic               back;
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic fixed;
        res_t res;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [OP_W-1:0]            operation;
    logic [TIME_W-1:0]          now_ms;
    logic signed [VAL_W-1:0]    accel_sample;
    logic [STEPS_W-1:0]         move_steps;
    logic                       move_backward;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [EV_W-1:0]            event_res;
    logic                       step_pulse;
    logic                       step_reverse;
    logic                       release_motor;
    logic [STEPS_W-1:0]         steps_left;
    logic signed [VAL_W-1:0]    instant_value;
    logic signed [VAL_W-1:0]    mean_value;

    paced_stepper_with_rolling_average_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .now_ms        (now_ms),
        .accel_sample  (accel_sample),
        .move_steps    (move_steps),
        .move_backward (move_backward),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .step_pulse    (step_pulse),
        .step_reverse  (step_reverse),
        .release_motor (release_motor),
        .steps_left    (steps_left),
        .instant_value (instant_value),
        .mean_value    (mean_value)
    );

    // Shadow state of the stepper and the sample ring
    logic signed [VAL_W-1:0]    ring_copy [RING_DEPTH];
    int unsigned                slot_copy;
    int unsigned                fill_copy;
    logic [TIME_W-1:0]          t_sample;
    logic [TIME_W-1:0]          t_report;
    logic [TIME_W-1:0]          t_step;
    logic [STEPS_W-1:0]         steps_due;
    logic                       dir_back;
    logic [CFG_W-1:0]           sample_gap;
    logic [CFG_W-1:0]           report_gap;
    logic [CFG_W-1:0]           step_gap;

    res_t                       awaited_events [$];
    dir_row_t                   dir_tab [$];
    logic [TIME_W-1:0]          clock_ms;
    int                         errors = 0;
    int                         idle_pct = ACTIVE_PCT;
    int                         stall_pct = ACTIVE_PCT;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Compute the event one transaction causes; returns 1 when there is one
    function automatic bit predict_event(input cmd_t c, output res_t r);
        logic [TIME_W-1:0] dt;
        longint            acc;
        r = '0;
        if (c.op == OP_START)
        begin
            r.steps_left = steps_due;
            if (c.steps == '0)
                r.event_res = EV_INVALID;
            else if (steps_due != '0)
                r.event_res = EV_BUSY;
            else
            begin
                dir_back     = c.back;
                steps_due    = c.steps;
                t_step       = c.now;
                r.event_res  = EV_ACCEPTED;
                r.steps_left = c.steps;
            end
            return 1'b1;
        end
        if (c.op == OP_STOP)
        begin
            steps_due       = '0;
            r.event_res     = EV_STOPPED;
            r.release_motor = 1'b1;
            return 1'b1;
        end
        if (c.op == OP_RESTART)
        begin
            slot_copy = 0;
            fill_copy = 0;
            t_sample  = c.now;
            t_report  = c.now;
            steps_due = '0;
            return 1'b0;
        end
        // tick during a move: pace the steps
        if (steps_due != '0)
        begin
            dt = c.now - t_step;
            if (dt < TIME_W'(step_gap))
                return 1'b0;
            t_step          = c.now;
            steps_due       = steps_due - 1'b1;
            r.event_res     = EV_STEP;
            r.step_pulse    = 1'b1;
            r.step_reverse  = dir_back;
            r.release_motor = (steps_due == '0);
            r.steps_left    = steps_due;
            r.instant_value = c.sample;
            return 1'b1;
        end
        // idle tick: store a sample, maybe report
        dt = c.now - t_sample;
        if (dt < TIME_W'(sample_gap))
            return 1'b0;
        t_sample             = c.now;
        ring_copy[slot_copy] = c.sample;
        slot_copy            = (slot_copy + 1) % RING_DEPTH;
        if (fill_copy < RING_DEPTH)
            fill_copy++;
        dt = c.now - t_report;
        if (dt < TIME_W'(report_gap))
            return 1'b0;
        t_report = c.now;
        acc      = 0;
        for (int i = 0; i < fill_copy; i++)
            acc += ring_copy[i];
        r.event_res     = EV_REPORT;
        r.instant_value = c.sample;
        r.mean_value    = VAL_W'(acc / longint'(fill_copy));
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                                    input logic [VAL_W-1:0] sample,
                                    input logic [STEPS_W-1:0] steps, input logic back,
                                    input bit fixed, input logic [EV_W-1:0] ev,
                                    input logic rel, input logic [STEPS_W-1:0] left);
        dir_row_t row;
        row                   = '0;
        row.cmd               = '{op, now, sample, steps, back};
        row.fixed             = fixed;
        row.res.event_res     = ev;
        row.res.release_motor = rel;
        row.res.steps_left    = left;
        dir_tab.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
        end
    endfunction

    // Present one transaction, hold it until accepted, then queue its event
    task automatic send_cmd(input cmd_t c, input bit fixed, input res_t typed);
        res_t r;
        bit   fires;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        operation     = c.op;
        now_ms        = c.now;
        accel_sample  = c.sample;
        move_steps    = c.steps;
        move_backward = c.back;
        do
            @(posedge clk);
        while (in_stall);
        fires = predict_event(c, r);
        if (fixed)
            awaited_events.push_back(typed);
        else if (fires)
            awaited_events.push_back(r);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SAMPLE_INTERVAL: sample_gap = val;
            REG_REPORT_INTERVAL: report_gap = val;
            REG_STEP_DELAY:      step_gap   = val;
            default: ;
        endcase
    endtask

    // Wait for every queued event, then let a report in flight finish
    task automatic settle();
        in_valid = 1'b0;
        while (awaited_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly ticks paced around the active interval, plus commands and time jumps
    task automatic random_phase(input int n, input int cmd_pct);
        cmd_t        c;
        int unsigned span;
        int unsigned sub;
        for (int k = 0; k < n; k++)
        begin
            c.sample = VAL_W'($urandom);
            c.steps  = STEPS_W'($urandom);
            c.back   = 1'($urandom);
            if ($urandom_range(9) == 0)
                c.sample = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            span = (steps_due != '0) ? step_gap : sample_gap;
            if ($urandom_range(99) >= cmd_pct)
            begin
                c.op     = OP_TICK;
                clock_ms = clock_ms + $urandom_range(2 * span);
            end
            else
            begin
                sub      = $urandom_range(19);
                clock_ms = clock_ms + $urandom_range(3);
                if (sub < 8)
                begin
                    c.op = OP_START;
                    case ($urandom_range(7))
                        0:       c.steps = '0;
                        1:       ;
                        default: c.steps = STEPS_W'($urandom_range(6, 1));
                    endcase
                end
                else if (sub < 13)
                    c.op = OP_STOP;
                else if (sub < 15)
                    c.op = OP_RESTART;
                else
                begin
                    c.op     = OP_TICK;
                    clock_ms = $urandom;
                end
            end
            c.now = clock_ms;
            send_cmd(c, 1'b0, '0);
        end
    endtask

    // Output side: random back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_events.size() == 0)
            begin
                $error("result transaction with none expected: event_res %0d", event_res);
                errors++;
            end
            else
            begin
                want = awaited_events.pop_front();
                check_field("event_res",     16'(want.event_res),  16'(event_res));
                check_field("step_pulse",    16'(want.step_pulse), 16'(step_pulse));
                check_field("step_reverse",  16'(want.step_reverse), 16'(step_reverse));
                check_field("release_motor", 16'(want.release_motor), 16'(release_motor));
                check_field("steps_left",    want.steps_left,      steps_left);
                check_field("instant_value", want.instant_value,   instant_value);
                check_field("mean_value",    want.mean_value,      mean_value);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_TICK;
        now_ms        = '0;
        accel_sample  = '0;
        move_steps    = '0;
        move_backward = 1'b0;

        // shadow state after reset
        slot_copy  = 0;
        fill_copy  = 0;
        t_sample   = '0;
        t_report   = '0;
        t_step     = '0;
        steps_due  = '0;
        dir_back   = 1'b0;
        sample_gap = SAMPLE_INTERVAL_RST;
        report_gap = REPORT_INTERVAL_RST;
        step_gap   = STEP_DELAY_RST;
        foreach (ring_copy[i])
            ring_copy[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset register values
        // stop while idle, zero-step start, sampling and a first report
        add_row(OP_STOP,    32'd0,   16'h0000, 16'd0,     1'b0, TYPED,    EV_STOPPED,  1'b1, 16'd0);
        add_row(OP_START,   32'd0,   16'h0000, 16'd0,     1'b0, TYPED,    EV_INVALID,  1'b0, 16'd0);
        add_row(OP_TICK,    32'd50,  16'h0005, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd100, 16'h7FFF, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd200, 16'h8000, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd500, 16'h0007, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        // short backward move; busy and zero-step while moving
        add_row(OP_START,   32'd510, 16'h0000, 16'd3,     1'b1, TYPED,    EV_ACCEPTED, 1'b0, 16'd3);
        add_row(OP_START,   32'd511, 16'h0000, 16'd5,     1'b0, TYPED,    EV_BUSY,     1'b0, 16'd3);
        add_row(OP_START,   32'd512, 16'h0000, 16'd0,     1'b0, TYPED,    EV_INVALID,  1'b0, 16'd3);
        add_row(OP_TICK,    32'd520, 16'h0001, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd530, 16'hFFFF, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd550, 16'h0064, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd570, 16'hFF9C, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        // longest move, cut short by stop
        add_row(OP_START,   32'd600, 16'h0000, 16'hFFFF,  1'b0, TYPED,    EV_ACCEPTED, 1'b0, 16'hFFFF);
        add_row(OP_TICK,    32'd620, 16'h0000, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_STOP,    32'd621, 16'h0000, 16'd0,     1'b0, TYPED,    EV_STOPPED,  1'b1, 16'd0);
        // restart, then a negative mean that truncates toward zero
        add_row(OP_RESTART, 32'd700, 16'h0000, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd800, 16'hFFFD, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_TICK,    32'd1200, 16'hFFFC, 16'd0,    1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        // time wraps through zero
        add_row(OP_RESTART, 32'hFFFF_FFF0, 16'h0000, 16'd0, 1'b0, BY_MODEL, EV_STEP,   1'b0, 16'd0);
        add_row(OP_TICK,    32'h0000_0054, 16'h7FFF, 16'd0, 1'b0, BY_MODEL, EV_STEP,   1'b0, 16'd0);
        add_row(OP_TICK,    32'h0000_01E4, 16'h8000, 16'd0, 1'b0, BY_MODEL, EV_STEP,   1'b0, 16'd0);
        add_row(OP_START,   32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 1'b1, TYPED,   EV_ACCEPTED, 1'b0, 16'hFFFF);
        add_row(OP_TICK,    32'd19,  16'h0001, 16'd0,     1'b0, BY_MODEL, EV_STEP,     1'b0, 16'd0);
        add_row(OP_STOP,    32'd20,  16'h0000, 16'd0,     1'b0, TYPED,    EV_STOPPED,  1'b1, 16'd0);

        foreach (dir_tab[i])
            send_cmd(dir_tab[i].cmd, dir_tab[i].fixed, dir_tab[i].res);
        clock_ms = 32'd20;

        // shortest intervals, no idling on either side
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(REG_SAMPLE_INTERVAL, 16'd1);
        write_reg(REG_REPORT_INTERVAL, 16'd1);
        write_reg(REG_STEP_DELAY,      16'd1);
        random_phase(120, 10);

        // longest intervals, starting just below the time wrap
        settle();
        idle_pct  = ACTIVE_PCT;
        stall_pct = ACTIVE_PCT;
        write_reg(REG_SAMPLE_INTERVAL, 16'hFFFF);
        write_reg(REG_REPORT_INTERVAL, 16'hFFFF);
        write_reg(REG_STEP_DELAY,      16'hFFFF);
        clock_ms = 32'hFFFE_0000;
        random_phase(85, 28);

        // modest random intervals; the unmapped index must change nothing
        settle();
        write_reg(REG_SAMPLE_INTERVAL, CFG_W'($urandom_range(400, 1)));
        write_reg(REG_REPORT_INTERVAL, CFG_W'($urandom_range(2000, 1)));
        write_reg(REG_STEP_DELAY,      CFG_W'($urandom_range(100, 1)));
        write_reg(REG_SPARE,           CFG_W'($urandom));
        random_phase(85, 28);

        // full-range random intervals
        settle();
        write_reg(REG_SAMPLE_INTERVAL, CFG_W'($urandom_range(65535, 1)));
        write_reg(REG_REPORT_INTERVAL, CFG_W'($urandom_range(65535, 1)));
        write_reg(REG_STEP_DELAY,      CFG_W'($urandom_range(65535, 1)));
        random_phase(85, 28);

        // back to the reset values
        settle();
        write_reg(REG_SAMPLE_INTERVAL, SAMPLE_INTERVAL_RST);
        write_reg(REG_REPORT_INTERVAL, REPORT_INTERVAL_RST);
        write_reg(REG_STEP_DELAY,      STEP_DELAY_RST);
        random_phase(85, 28);

        settle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### paced_stepper_with_rolling_average_core.f
hdl/psra_pkg.sv
hdl/paced_stepper_with_rolling_average_core.sv
test/tb_paced_stepper_with_rolling_average_core.sv
